/* hw/rtl/paycc_pkg.sv */
// ----------------------------------------------------------------------------
// paycc_pkg: palette ARGB to A+YCbCr converter package
// Register map, conversion coefficients and a small helper function.
// ----------------------------------------------------------------------------
package paycc_pkg;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_ALPHA_GAIN   = 2'd0,
    REG_ALPHA_OFFSET = 2'd1,
    REG_MIXER_FLAGS  = 2'd2,
    REG_RGB_OUTPUT   = 2'd3
  } reg_idx_e;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  // mixer flag bits
  localparam int unsigned MixHalfBit = 0;
  localparam int unsigned MixGrayBit = 1;

  // x/100 as (x * 83887) >> 23, exact for x < 65536
  localparam logic [16:0] AlphaRecip = 17'd83887;
  localparam int unsigned AlphaShift = 23;
  // x/3 as (x * 683) >> 11, exact for x <= 765
  localparam logic [9:0]  ThirdRecip = 10'd683;
  localparam int unsigned ThirdShift = 11;

  // BT.601 studio range coefficients
  localparam logic signed [17:0] KyR  = 18'sd66;
  localparam logic signed [17:0] KyG  = 18'sd129;
  localparam logic signed [17:0] KyB  = 18'sd25;
  localparam logic signed [17:0] KcrR = 18'sd112;
  localparam logic signed [17:0] KcrG = -18'sd94;
  localparam logic signed [17:0] KcrB = -18'sd18;
  localparam logic signed [17:0] KcbR = -18'sd38;
  localparam logic signed [17:0] KcbG = -18'sd74;
  localparam logic signed [17:0] KcbB = 18'sd112;
  localparam logic signed [17:0] Round = 18'sd128;

  localparam logic [7:0] LumaOffset   = 8'd16;
  localparam logic [7:0] ChromaOffset = 8'd128;
  localparam logic [7:0] LumaMin      = 8'd16;
  localparam logic [7:0] LumaMax      = 8'd235;
  localparam logic [7:0] ChromaMin    = 8'd16;
  localparam logic [7:0] ChromaMax    = 8'd240;
  localparam logic [7:0] GrayChroma   = 8'h80;
  localparam logic [7:0] AlphaTopBit  = 8'h80;

  // saturate a signed value into lo..hi
  function automatic logic [7:0] clamp_u8(logic signed [17:0] v, logic [7:0] lo,
                                          logic [7:0] hi);
    logic [7:0] res;
    if (v < $signed({10'b0, lo})) begin
      res = lo;
    end else if (v > $signed({10'b0, hi})) begin
      res = hi;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/palette_argb_to_aycbcr.sv */
// ----------------------------------------------------------------------------
// palette_argb_to_aycbcr: palette entry converter
// Turns ARGB palette entries into corrected alpha plus RGB or Y Cb Cr.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: one ARGB palette entry per beat, top-layer flag on tuser,
//   end of palette on tlast. Output stream: one colour-table entry per beat
//   (alpha, red or Y, green or Cb, blue or Cr), tlast copied through.
//   Each entry is held in an input register, converted in one combinational
//   pass, and caught in the output register. Throughput is one entry per
//   cycle while the receiver takes beats; the single 8x25 alpha multiply
//   and the constant colour matrix sit in that pass.
//   The APB port sets gain, offset, mixer flags and output mode; write it
//   only while no entry is in flight. A gain write also loads the scaled
//   gain used for the divide by 100.
//   Reset empties both stages and loads gain 0, offset 0, flags 0 and RGB
//   output mode.
//   When the receiver stalls, the output register holds its beat and the
//   input register can still take one more entry before s_axis_tready drops.
// ----------------------------------------------------------------------------
module palette_argb_to_aycbcr
  import paycc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // argb_color[31:0]
  input  logic                 s_axis_tuser,   // top_layer
  input  logic                 s_axis_tlast,
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // alpha_out[7:0], red_or_luma[15:8], green_or_cb[23:16], blue_or_cr[31:24]
  output logic [31:0]          m_axis_tdata,
  output logic                 m_axis_tlast,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  // configuration registers
  logic [8:0]  gain_q, offset_q;
  logic [1:0]  mix_q;
  logic        rgb_q;
  logic [24:0] gscale_q, gscale_d;
  logic [8:0]  gain_mag;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  // |gain| * 83887, so per entry only one multiply by alpha is left
  assign gain_mag = pwdata[8] ? 9'(-pwdata[8:0]) : pwdata[8:0];
  assign gscale_d = {16'b0, gain_mag} * {8'b0, AlphaRecip};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= '0;
      offset_q <= '0;
      mix_q    <= '0;
      rgb_q    <= 1'b1;
      gscale_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ALPHA_GAIN: begin
          gain_q   <= pwdata[8:0];
          gscale_q <= gscale_d;
        end
        REG_ALPHA_OFFSET: offset_q <= pwdata[8:0];
        REG_MIXER_FLAGS:  mix_q    <= pwdata[1:0];
        REG_RGB_OUTPUT:   rgb_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ALPHA_GAIN:   prdata = {23'b0, gain_q};
      REG_ALPHA_OFFSET: prdata = {23'b0, offset_q};
      REG_MIXER_FLAGS:  prdata = {30'b0, mix_q};
      REG_RGB_OUTPUT:   prdata = {31'b0, rgb_q};
      default:          prdata = '0;
    endcase
  end

  // pipeline control
  logic        s1_valid_q, out_valid_q;
  logic [31:0] s1_argb_q;
  logic        s1_top_q, s1_last_q;
  logic [31:0] out_data_q, out_data_d;
  logic        out_last_q;
  logic        out_ready, s1_adv, s_acc;

  assign out_ready     = ~out_valid_q | m_axis_tready;
  assign s1_adv        = s1_valid_q & out_ready;
  assign s_axis_tready = ~s1_valid_q | out_ready;
  assign s_acc         = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_argb_q <= s_axis_tdata;
      s1_top_q  <= s_axis_tuser;
      s1_last_q <= s_axis_tlast;
    end
    if (s1_adv) begin
      out_data_q <= out_data_d;
      out_last_q <= s1_last_q;
    end
  end

  // conversion
  logic [7:0]         a, r, g, b;
  logic [32:0]        gprod;
  logic [9:0]         qmag;
  logic signed [11:0] q, alpha_sum;
  logic [7:0]         alpha_c, alpha_f;
  logic signed [17:0] rs, gs, bs, y_sum, cr_sum, cb_sum;
  logic signed [17:0] y_v, cr_v, cb_v;
  logic [7:0]         c0, c1, c2, c0_f, c1_f, c2_f;
  logic [9:0]         gray_sum;
  logic [19:0]        gray_prod;
  logic [7:0]         gray_avg;
  logic               mix_en;

  assign a = s1_argb_q[31:24];
  assign r = s1_argb_q[23:16];
  assign g = s1_argb_q[15:8];
  assign b = s1_argb_q[7:0];

  // alpha + gain*alpha/100 (toward zero) + offset
  assign gprod     = {8'b0, gscale_q} * {25'b0, a};
  assign qmag      = gprod[AlphaShift +: 10];
  assign q         = gain_q[8] ? -$signed({2'b0, qmag}) : $signed({2'b0, qmag});
  assign alpha_sum = $signed({4'b0, a}) + q + $signed({{3{offset_q[8]}}, offset_q});

  always_comb begin
    if (alpha_sum < 12'sd0) begin
      alpha_c = 8'd0;
    end else if (alpha_sum > 12'sd255) begin
      alpha_c = 8'd255;
    end else begin
      alpha_c = alpha_sum[7:0];
    end
  end

  assign rs = $signed({10'b0, r});
  assign gs = $signed({10'b0, g});
  assign bs = $signed({10'b0, b});

  assign y_sum  = KyR * rs + KyG * gs + KyB * bs + Round;
  assign cr_sum = KcrR * rs + KcrG * gs + KcrB * bs + Round;
  assign cb_sum = KcbR * rs + KcbG * gs + KcbB * bs + Round;

  assign y_v  = (y_sum >>> 8) + $signed({10'b0, LumaOffset});
  assign cr_v = (cr_sum >>> 8) + $signed({10'b0, ChromaOffset});
  assign cb_v = (cb_sum >>> 8) + $signed({10'b0, ChromaOffset});

  always_comb begin
    if (rgb_q) begin
      c0 = r;
      c1 = g;
      c2 = b;
    end else begin
      c0 = clamp_u8(y_v, LumaMin, LumaMax);
      c1 = clamp_u8(cb_v, ChromaMin, ChromaMax);
      c2 = clamp_u8(cr_v, ChromaMin, ChromaMax);
    end
  end

  // rgb average, only used in rgb mode where c0..c2 are r, g, b
  assign gray_sum  = {2'b0, r} + {2'b0, g} + {2'b0, b};
  assign gray_prod = {10'b0, gray_sum} * {10'b0, ThirdRecip};
  assign gray_avg  = gray_prod[ThirdShift +: 8];

  assign mix_en = ~s1_top_q;

  always_comb begin
    alpha_f = alpha_c;
    c0_f    = c0;
    c1_f    = c1;
    c2_f    = c2;
    if (mix_en && mix_q[MixHalfBit]) begin
      alpha_f = {1'b0, alpha_c[7:1]} | AlphaTopBit;
    end
    if (mix_en && mix_q[MixGrayBit]) begin
      if (rgb_q) begin
        c0_f = gray_avg;
        c1_f = gray_avg;
        c2_f = gray_avg;
      end else begin
        c1_f = GrayChroma;
        c2_f = GrayChroma;
      end
    end
  end

  assign out_data_d    = {c2_f, c1_f, c0_f, alpha_f};
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  // an empty input stage always takes a beat
  a_s1_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> s_axis_tready)
    else $error("input stage empty but not ready");

  // an accepted beat lands in the input stage
  a_acc_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> s1_valid_q)
    else $error("accepted beat lost");

  // a held entry keeps its contents until it moves on
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_argb_q) && $stable(s1_last_q)))
    else $error("input stage changed while stalled");

  // output drains when nothing follows
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && m_axis_tready && !s1_valid_q) |=> !m_axis_tvalid)
    else $error("output beat repeated");
`endif

endmodule
